>>> hw/rtl/heartbeat_health_table_assert.svh
// Assertion macros shared by the checkers of the heartbeat health table.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef HEARTBEAT_HEALTH_TABLE_ASSERT_SVH
`define HEARTBEAT_HEALTH_TABLE_ASSERT_SVH

// A property that must hold at every sampled edge.
`define HHT_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("heartbeat health table: rule broken");

// A consequent that must hold in the cycle after its antecedent.
`define HHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("heartbeat health table: next-cycle rule broken");

`endif

>>> hw/rtl/hht_pkg.sv
// Package of the heartbeat health table: widths, health codes, register indexes
// and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package hht_pkg;

	localparam int NUM_SERVERS_DEF = 32;

	localparam int TIME_W    = 32;
	localparam int ID_W      = 5;
	localparam int HEALTH_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 32;

	// Wide enough to compare a server id against any table depth up to 64.
	localparam int ID_CMP_W = 7;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 8;

	localparam logic [HEALTH_W-1:0] HEALTH_ONLINE   = 2'd0;
	localparam logic [HEALTH_W-1:0] HEALTH_UNSTABLE = 2'd1;
	localparam logic [HEALTH_W-1:0] HEALTH_OFFLINE  = 2'd2;

	localparam logic CMD_HEARTBEAT = 1'b0;
	localparam logic CMD_CHECK     = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MISS_TIMEOUT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFLINE_TIMEOUT = 1'b1;

	localparam logic [TIME_W-1:0] MISS_TIMEOUT_RESET    = 32'd3000;
	localparam logic [TIME_W-1:0] OFFLINE_TIMEOUT_RESET = 32'd30000;

	typedef struct packed {
		logic hb_write;   // store the heartbeat of the accepted request
		logic start_scan; // capture the check time and rewind the scan counter
		logic run;        // let the scan pipeline advance
		logic flush;      // move the held report to the output, marked last
	} hht_cmd_t;

	typedef struct packed {
		logic issue_done; // every table entry has been read
		logic pipe_busy;  // an entry is still in a pipeline stage
		logic pend_valid; // a report is held back awaiting its successor
		logic out_free;   // the output register can take a report this cycle
	} hht_status_t;

endpackage

>>> hw/rtl/hht_ctrl.sv
// Controller of the heartbeat health table: accepts requests and sequences a
// check scan. Depends on hht_pkg.
`timescale 1ns / 1ps

module hht_ctrl
	import hht_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_cmd,
	input  hht_status_t status,
	output logic        s_tready,
	output hht_cmd_t    cmd
);

	localparam int ST_W = 2;
	localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
	localparam logic [ST_W-1:0] ST_SCAN  = 2'd1;
	localparam logic [ST_W-1:0] ST_FLUSH = 2'd2;

	logic [ST_W-1:0] state_q;
	logic [ST_W-1:0] state_d;
	logic            accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d        = state_q;
		cmd.hb_write   = 1'b0;
		cmd.start_scan = 1'b0;
		cmd.run        = 1'b0;
		cmd.flush      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (s_cmd == CMD_HEARTBEAT)) begin
					cmd.hb_write = 1'b1;
				end
				if (accept && (s_cmd == CMD_CHECK)) begin
					cmd.start_scan = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.run = 1'b1;
				if (status.issue_done && !status.pipe_busy) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// The report still held is the final one of this check.
				if (!status.pend_valid) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/hht_dp.sv
// Datapath of the heartbeat health table: timeout registers, the beat time and
// health memories, the scan pipeline and the report buffers. Depends on hht_pkg.
`timescale 1ns / 1ps

module hht_dp
	import hht_pkg::*;
#(
	parameter int NUM_SERVERS = NUM_SERVERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [ID_W-1:0]      in_id,
	input  logic [TIME_W-1:0]    in_now,
	input  hht_cmd_t             cmd,
	output hht_status_t          status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ID_W-1:0]      out_id,
	output logic [HEALTH_W-1:0]  out_health,
	output logic                 out_last
);

	localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int CNT_W = $clog2(NUM_SERVERS + 1);

	logic [TIME_W-1:0]   miss_q;
	logic [TIME_W-1:0]   offline_q;
	logic [TIME_W-1:0]   now_q;

	logic [TIME_W-1:0]   beat_mem   [NUM_SERVERS];
	logic [HEALTH_W-1:0] health_mem [NUM_SERVERS];
	logic [NUM_SERVERS-1:0] valid_q;

	logic [CNT_W-1:0]    cnt_q;
	logic                issue;
	logic [IDX_W-1:0]    rd_addr;
	logic                adv;

	logic                v_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [TIME_W-1:0]   beat_s1;
	logic [HEALTH_W-1:0] health_s1;

	logic                v_s2;
	logic [IDX_W-1:0]    idx_s2;
	logic [TIME_W-1:0]   elapsed_s2;
	logic [HEALTH_W-1:0] health_s2;
	logic [HEALTH_W-1:0] target_s2;
	logic                change_s2;

	logic                hb_hit;
	logic [IDX_W-1:0]    hb_addr;
	logic                hlt_we;
	logic [IDX_W-1:0]    hlt_wa;
	logic [HEALTH_W-1:0] hlt_wd;

	logic                pend_valid_q;
	logic [ID_W-1:0]     pend_id_q;
	logic [HEALTH_W-1:0] pend_health_q;

	logic                out_valid_q;
	logic [ID_W-1:0]     out_id_q;
	logic [HEALTH_W-1:0] out_health_q;
	logic                out_last_q;
	logic                out_free;
	logic                push_pend;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q    <= MISS_TIMEOUT_RESET;
			offline_q <= OFFLINE_TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MISS_TIMEOUT:    miss_q    <= cfg_data;
				REG_OFFLINE_TIMEOUT: offline_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Heartbeats for ids beyond the table are dropped.
	assign hb_hit  = cmd.hb_write && (ID_CMP_W'(in_id) < ID_CMP_W'(NUM_SERVERS));
	assign hb_addr = IDX_W'(in_id);

	assign out_free = !out_valid_q || out_ready;
	// The scan stalls only when both the held report and the output are occupied.
	assign adv      = cmd.run && (!pend_valid_q || out_free);
	assign issue    = (cnt_q != CNT_W'(NUM_SERVERS));
	assign rd_addr  = issue ? cnt_q[IDX_W-1:0] : '0;

	always_comb begin
		if (elapsed_s2 < miss_q) begin
			target_s2 = HEALTH_ONLINE;
		end else if (elapsed_s2 < offline_q) begin
			target_s2 = HEALTH_UNSTABLE;
		end else begin
			target_s2 = HEALTH_OFFLINE;
		end
	end

	assign change_s2 = v_s2 && (target_s2 != health_s2);

	assign hlt_we = (hb_hit && !valid_q[hb_addr]) || (adv && change_s2);
	assign hlt_wa = hb_hit ? hb_addr : idx_s2;
	assign hlt_wd = hb_hit ? HEALTH_UNSTABLE : target_s2;

	// Memories with registered reads; the read registers form stage one.
	always_ff @(posedge clk) begin
		if (hb_hit) begin
			beat_mem[hb_addr] <= in_now;
		end
		if (adv) begin
			beat_s1 <= beat_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (hlt_we) begin
			health_mem[hlt_wa] <= hlt_wd;
		end
		if (adv) begin
			health_s1 <= health_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (hb_hit) begin
			valid_q[hb_addr] <= 1'b1;
		end
	end

	// Scan control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else if (cmd.start_scan) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else if (adv) begin
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			v_s1 <= issue && valid_q[rd_addr];
			v_s2 <= v_s1;
		end
	end

	// Scan payload.
	always_ff @(posedge clk) begin
		if (cmd.start_scan) begin
			now_q <= in_now;
		end
		if (adv) begin
			idx_s1     <= rd_addr;
			idx_s2     <= idx_s1;
			elapsed_s2 <= now_q - beat_s1;
			health_s2  <= health_s1;
		end
	end

	// A report is held until the next one appears or the scan ends, so that
	// the final report of a check can be marked last.
	assign push_pend = (adv && change_s2 && pend_valid_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (adv && change_s2) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push_pend) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && change_s2) begin
			pend_id_q     <= ID_W'(idx_s2);
			pend_health_q <= target_s2;
		end
		if (push_pend) begin
			out_id_q     <= pend_id_q;
			out_health_q <= pend_health_q;
			out_last_q   <= cmd.flush;
		end
	end

	assign status.issue_done = !issue;
	assign status.pipe_busy  = v_s1 || v_s2;
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = out_free;

	assign out_valid  = out_valid_q;
	assign out_id     = out_id_q;
	assign out_health = out_health_q;
	assign out_last   = out_last_q;

endmodule

>>> hw/rtl/heartbeat_health_table.sv
// Heartbeat health table, top level: stream ports and the configuration port.
// Depends on hht_pkg, hht_ctrl and hht_dp.
//
// Usage. Requests arrive on the s_ channel: s_tuser[0] selects a heartbeat (0)
// or a health check (1). A heartbeat stores now_ms as the last beat time of its
// server and creates the entry as unstable if it was unknown; a heartbeat can be
// accepted in every cycle while no check is in progress. Heartbeats for ids at
// or beyond NUM_SERVERS are dropped.
// A check reads the table one entry per cycle through the beat time memory while
// the output does not stall, and keeps s_tready low until the scan is over and
// any held report is in the output register; the scan ends sooner when the last
// two entries are not in use. Each entry whose health changes gives one report
// on the m_ channel; a report is held until the next one is found or the scan
// ends, and the final one carries m_tlast. When the receiver stalls with one
// report in the output register and one held, the scan pauses until m_tready
// returns; nothing is dropped. Reset clears all valid marks and loads the
// timeouts with 3000 and 30000 ms. No clearing pass follows reset. Timeouts are
// written through cfg_we, cfg_index and cfg_data; the user must write them only
// while no request is in progress, as the block does not enforce it.
`timescale 1ns / 1ps

module heartbeat_health_table
	import hht_pkg::*;
#(
	parameter int NUM_SERVERS = NUM_SERVERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [4:0] server_id, [36:5] now_ms, rest zero
	input  logic [S_TUSER_W-1:0] s_tuser,  // [0] cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [4:0] changed_id, [6:5] new_health, [7] zero
	output logic                 m_tlast
);

	hht_cmd_t            cmd;
	hht_status_t         status;
	logic [ID_W-1:0]     out_id;
	logic [HEALTH_W-1:0] out_health;

	hht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_cmd    (s_tuser[0]),
		.status   (status),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	hht_dp #(
		.NUM_SERVERS (NUM_SERVERS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_id      (s_tdata[ID_W-1:0]),
		.in_now     (s_tdata[ID_W+TIME_W-1:ID_W]),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_id     (out_id),
		.out_health (out_health),
		.out_last   (m_tlast)
	);

	assign m_tdata = {1'b0, out_health, out_id};

endmodule

>>> hw/rtl/hht_chk.sv
// Port-level checker of the heartbeat health table and its bind to the top level.
// Depends on hht_pkg and heartbeat_health_table_assert.svh.
`timescale 1ns / 1ps
`include "heartbeat_health_table_assert.svh"

module hht_chk
	import hht_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TUSER_W-1:0] s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tlast
);

	// A stalled report stays offered and unchanged.
	`HHT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`HHT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

	// An accepted check blocks further requests while the table is scanned.
	`HHT_ASSERT_NEXT(a_check_busy, s_tvalid && s_tready && s_tuser[0], !s_tready)

	// Reports are produced only by a scan, never in a cycle open for requests.
	`HHT_ASSERT_ALWAYS(a_report_in_scan, $rose(m_tvalid) |-> !$past(s_tready))

endmodule

bind heartbeat_health_table hht_chk u_chk (.*);

>>> test/tb_heartbeat_health_table.sv
// Self-checking testbench for the heartbeat health table: drives heartbeat and
// check requests, predicts every health change and compares each report.
// Depends on hht_pkg and heartbeat_health_table.
`timescale 1ns / 1ps

module tb_heartbeat_health_table;
	import hht_pkg::*;

	localparam int TABLE_DEPTH   = NUM_SERVERS_DEF;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_ITEMS  = 380;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [HEALTH_W-1:0] health;
		logic                is_last;
	} health_report_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;  // [4:0] server_id, [36:5] now_ms, rest zero
	logic [S_TUSER_W-1:0] s_tuser = '0;  // [0] cmd
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;       // [4:0] changed_id, [6:5] new_health, [7] zero
	logic                 m_tlast;

	// Mirror of the table and the timeout registers.
	logic                entry_known [TABLE_DEPTH];
	logic [TIME_W-1:0]   beat_ms     [TABLE_DEPTH];
	logic [HEALTH_W-1:0] entry_health[TABLE_DEPTH];
	logic [TIME_W-1:0]   miss_ms;
	logic [TIME_W-1:0]   offline_ms;

	health_report_t pending_changes[$];

	logic [TIME_W-1:0] wall_ms;
	logic [TIME_W-1:0] step_span;
	bit                sender_idles = 1'b1;
	bit                sink_idles = 1'b1;
	int                sink_wait = 0;
	int                sink_hold = 0;

	int unsigned error_count = 0;
	int unsigned beats_sent = 0;
	int unsigned checks_sent = 0;
	int unsigned reports_seen = 0;
	int unsigned settings_used = 0;

	heartbeat_health_table #(
		.NUM_SERVERS(TABLE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		int unsigned cycles_run;
		cycles_run = 0;
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("Run stopped after %0d cycles with %0d reports outstanding.",
			cycles_run, pending_changes.size());
		$display("[heartbeat_health_table] ERROR");
		$finish;
	end

	function automatic logic [HEALTH_W-1:0] health_for_elapsed(logic [TIME_W-1:0] elapsed);
		// The online bound is tested first, so inverted timeouts never give unstable.
		if (elapsed < miss_ms)
			return HEALTH_ONLINE;
		if (elapsed < offline_ms)
			return HEALTH_UNSTABLE;
		return HEALTH_OFFLINE;
	endfunction

	task automatic predict_request(logic cmd, logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
		health_report_t found[$];
		health_report_t r;
		logic [HEALTH_W-1:0] nxt;
		if (cmd == CMD_HEARTBEAT) begin
			if (int'(id) < TABLE_DEPTH) begin
				if (!entry_known[id]) begin
					entry_known[id] = 1'b1;
					entry_health[id] = HEALTH_UNSTABLE;
				end
				beat_ms[id] = now;
			end
		end else begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (entry_known[i]) begin
					nxt = health_for_elapsed(now - beat_ms[i]);
					if (nxt != entry_health[i]) begin
						entry_health[i] = nxt;
						r.id = i[ID_W-1:0];
						r.health = nxt;
						r.is_last = 1'b0;
						found.push_back(r);
					end
				end
			end
			for (int k = 0; k < found.size(); k++) begin
				r = found[k];
				r.is_last = (k == found.size() - 1);
				pending_changes.push_back(r);
			end
		end
	endtask

	// Receiver: checks each accepted report and draws its own stalls.
	always @(posedge clk) begin
		health_report_t want;
		if (m_tvalid && m_tready) begin
			reports_seen++;
			if (pending_changes.size() == 0) begin
				$error("unexpected report: changed_id %0d new_health %0d last %0d",
					m_tdata[ID_W-1:0], m_tdata[ID_W +: HEALTH_W], m_tlast);
				error_count++;
			end else begin
				want = pending_changes.pop_front();
				if (m_tdata[ID_W-1:0] !== want.id) begin
					$error("changed_id: expected %0d, got %0d", want.id, m_tdata[ID_W-1:0]);
					error_count++;
				end
				if (m_tdata[ID_W +: HEALTH_W] !== want.health) begin
					$error("new_health: expected %0d, got %0d",
						want.health, m_tdata[ID_W +: HEALTH_W]);
					error_count++;
				end
				if (m_tlast !== want.is_last) begin
					$error("last: expected %0d, got %0d", want.is_last, m_tlast);
					error_count++;
				end
			end
			sink_wait = sink_idles ? $urandom_range(0, 10) : 0;
		end
		if (sink_hold > 0) begin
			sink_hold--;
			m_tready <= 1'b0;
		end else if (sink_wait > 0) begin
			sink_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Called just after a rising edge; returns just after the accepting edge.
	task automatic send_request(logic cmd, logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
		int gap;
		gap = sender_idles ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - TIME_W - ID_W){1'b0}}, now, id};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		predict_request(cmd, id, now);
		if (cmd == CMD_HEARTBEAT)
			beats_sent++;
		else
			checks_sent++;
	endtask

	// A check that finds no change leaves no report behind, so allow for its scan.
	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		while (pending_changes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeouts(logic [TIME_W-1:0] miss, logic [TIME_W-1:0] offline);
		wait_until_drained();
		cfg_we <= 1'b1;
		cfg_index <= REG_MISS_TIMEOUT;
		cfg_data <= miss;
		@(posedge clk);
		cfg_index <= REG_OFFLINE_TIMEOUT;
		cfg_data <= offline;
		@(posedge clk);
		cfg_we <= 1'b0;
		miss_ms = miss;
		offline_ms = offline;
		settings_used++;
	endtask

	task automatic random_request();
		int roll;
		logic [ID_W-1:0] id;
		roll = $urandom_range(0, 99);
		wall_ms = wall_ms + $urandom_range(0, step_span);
		// Ids 0 to 7 beat often and stay fresh; the rest drift towards offline.
		id = (roll % 3 == 0) ? ID_W'($urandom_range(0, 31)) : ID_W'($urandom_range(0, 7));
		if (roll < 12)
			send_request(CMD_CHECK, ID_W'($urandom()), (roll < 2) ? $urandom() : wall_ms);
		else
			send_request(CMD_HEARTBEAT, id, (roll < 95) ? wall_ms : $urandom());
	endtask

	task automatic test_basic_ageing();
		sender_idles = 1'b1;
		sink_idles = 1'b1;
		send_request(CMD_CHECK, 5'd0, 32'd0);
		send_request(CMD_HEARTBEAT, 5'd0, 32'd0);
		send_request(CMD_HEARTBEAT, 5'd31, 32'hFFFF_FFFF);
		send_request(CMD_HEARTBEAT, 5'd0, 32'd10);
		// Elapsed time for server 31 wraps through zero here.
		send_request(CMD_CHECK, 5'd31, 32'd1000);
		send_request(CMD_CHECK, 5'd0, 32'd1000);
		send_request(CMD_CHECK, 5'd0, 32'd3010);
		send_request(CMD_CHECK, 5'd0, 32'd30010);
		send_request(CMD_HEARTBEAT, 5'd21, 32'd30010);
		send_request(CMD_HEARTBEAT, 5'd0, 32'd30010);
		send_request(CMD_CHECK, 5'd0, 32'd33009);
	endtask

	task automatic test_timeout_extremes();
		set_timeouts(32'd0, 32'd0);
		send_request(CMD_CHECK, 5'd0, 32'd33009);
		set_timeouts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(CMD_HEARTBEAT, 5'd3, 32'd0);
		send_request(CMD_CHECK, 5'd0, 32'hFFFF_FFFF);
		send_request(CMD_CHECK, 5'd0, 32'h0000_0001);
		set_timeouts(32'd0, 32'hFFFF_FFFF);
		send_request(CMD_CHECK, 5'd0, 32'h8000_0000);
		// Inverted bounds: a server is either online or offline.
		set_timeouts(32'd40000, 32'd500);
		send_request(CMD_HEARTBEAT, 5'd10, 32'h8000_0000);
		send_request(CMD_CHECK, 5'd0, 32'h8000_1000);
		send_request(CMD_CHECK, 5'd0, 32'h8001_0000);
	endtask

	task automatic test_backpressure();
		logic [TIME_W-1:0] base;
		set_timeouts(32'd1000, 32'd5000);
		sender_idles = 1'b0;
		sink_idles = 1'b0;
		base = $urandom();
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_request(CMD_HEARTBEAT, ID_W'(i), base + i);
		send_request(CMD_CHECK, 5'd0, base + 100);
		// Every server goes offline at once while the receiver stays stalled.
		sink_hold = 400;
		send_request(CMD_CHECK, 5'd0, base + 100000);
		for (int i = 0; i < 8; i++)
			send_request(CMD_HEARTBEAT, ID_W'($urandom_range(0, 31)), base + 100010);
		send_request(CMD_CHECK, 5'd0, base + 100020);
		wait_until_drained();
		sender_idles = 1'b1;
		sink_idles = 1'b1;
	endtask

	task automatic test_random_traffic();
		int per_setting;
		per_setting = RANDOM_ITEMS / 6;
		wall_ms = $urandom();
		for (int p = 0; p < 6; p++) begin
			case (p)
			0: begin
				set_timeouts(MISS_TIMEOUT_RESET, OFFLINE_TIMEOUT_RESET);
				step_span = 32'd4000;
			end
			1: begin
				set_timeouts(32'd50, 32'd400);
				step_span = 32'd80;
			end
			2: begin
				set_timeouts(32'd2000, 32'd300);
				step_span = 32'd1500;
			end
			3: begin
				set_timeouts($urandom(), $urandom());
				step_span = 32'hFFFF_FFFF >> $urandom_range(3, 8);
			end
			4: begin
				set_timeouts(32'd0, 32'd20);
				step_span = 32'd10;
			end
			default: begin
				set_timeouts(32'h4000_0000, 32'hFFFF_FFFF);
				step_span = 32'h1000_0000;
			end
			endcase
			for (int n = 0; n < per_setting; n++) begin
				if (n % 25 == 0) begin
					sender_idles = ($urandom_range(0, 3) != 0);
					sink_idles = ($urandom_range(0, 3) != 0);
				end
				random_request();
			end
		end
		wait_until_drained();
	endtask

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			entry_known[i] = 1'b0;
			beat_ms[i] = '0;
			entry_health[i] = HEALTH_ONLINE;
		end
		miss_ms = MISS_TIMEOUT_RESET;
		offline_ms = OFFLINE_TIMEOUT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ageing();
		test_timeout_extremes();
		test_backpressure();
		test_random_traffic();
		wait_until_drained();

		$display("Sent %0d heartbeats and %0d checks under %0d timeout settings.",
			beats_sent, checks_sent, settings_used);
		$display("Compared %0d health change reports, %0d mismatches.",
			reports_seen, error_count);
		if (error_count == 0)
			$display("[heartbeat_health_table] OK");
		else
			$display("[heartbeat_health_table] ERROR");
		$finish;
	end

endmodule
